/* src/pixel_point_operations_assert.svh */
// Assertion macros used by the top-level RTL file.
`ifndef PIXEL_POINT_OPERATIONS_ASSERT_SVH
`define PIXEL_POINT_OPERATIONS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PPO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ppo_pkg.sv */
`default_nettype none

package ppo_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned DATA_W    = NUM_LANES * BYTE_W;
  localparam int unsigned WGT_W     = 10;
  localparam int unsigned WSUM_W    = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

  // operation codes
  localparam logic [2:0] OP_NEGATIVE  = 3'd0;
  localparam logic [2:0] OP_BRIGHTEN  = 3'd1;
  localparam logic [2:0] OP_THRESHOLD = 3'd2;
  localparam logic [2:0] OP_SEPIA     = 3'd3;
  localparam logic [2:0] OP_GRAY      = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OPERATION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRUE_COLOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd2;

  typedef struct packed {
    logic [2:0]        op;
    logic              true_color;
    logic [BYTE_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } px_t;

  // Q0.10 weights applied to red, green, blue
  typedef struct packed {
    logic [WGT_W-1:0] wr;
    logic [WGT_W-1:0] wg;
    logic [WGT_W-1:0] wb;
  } wgt_t;

  typedef struct packed {
    logic [BYTE_W-1:0] res;  // lane-local result
    logic [BYTE_W-1:0] pix;  // input byte of this lane, for the merge
  } lane_out_t;

  // sepia weights per lane: 0 blue, 1 green, 2 red
  localparam wgt_t SEPIA_W [NUM_LANES] = '{
    '{wr: 10'd279, wg: 10'd547, wb: 10'd134},
    '{wr: 10'd357, wg: 10'd702, wb: 10'd172},
    '{wr: 10'd402, wg: 10'd787, wb: 10'd194}
  };

  localparam wgt_t GRAY_W = '{wr: 10'd307, wg: 10'd604, wb: 10'd113};

  localparam logic [11:0] THR_LIMIT = 12'd764;
  localparam logic [BYTE_W-1:0] THR8_LIMIT = 8'd127;

endpackage

`default_nettype wire

/* src/ppo_lane.sv */
`default_nettype none

module ppo_lane (
  input  wire                        clk_i,
  input  wire                        en_i,
  input  ppo_pkg::px_t               px_i,
  input  wire [ppo_pkg::BYTE_W-1:0]  own_i,
  input  ppo_pkg::wgt_t              wgt_i,
  input  ppo_pkg::cfg_t              cfg_i,
  output ppo_pkg::lane_out_t         out_o
);
  import ppo_pkg::*;

  logic [WSUM_W-1:0]   wsum;
  logic [WSUM_W-11:0]  wsh;
  logic [BYTE_W-1:0]   sepia;
  logic [BYTE_W:0]     bsum;
  logic [BYTE_W-1:0]   res_d;
  lane_out_t           out_q;

  always_comb begin
    wsum = WSUM_W'(wgt_i.wr * px_i.red) + WSUM_W'(wgt_i.wg * px_i.green)
         + WSUM_W'(wgt_i.wb * px_i.blue);
    wsh   = wsum[WSUM_W-1:10];
    sepia = (wsh > (WSUM_W-10)'(BYTE_MAX)) ? BYTE_MAX : wsh[BYTE_W-1:0];
    bsum  = {1'b0, own_i} + {1'b0, cfg_i.step};
  end

  // true-color threshold and gray are settled in the merge stage
  always_comb begin
    unique case (cfg_i.op)
      OP_NEGATIVE:  res_d = BYTE_MAX - own_i;
      OP_BRIGHTEN:  res_d = bsum[BYTE_W] ? BYTE_MAX : bsum[BYTE_W-1:0];
      OP_THRESHOLD: res_d = (own_i > THR8_LIMIT) ? BYTE_MAX : '0;
      OP_SEPIA:     res_d = sepia;
      default:      res_d = own_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.res <= res_d;
      out_q.pix <= own_i;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

/* src/ppo_merge.sv */
`default_nettype none

module ppo_merge (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          valid_i,
  input  wire                          last_i,
  input  ppo_pkg::lane_out_t           lanes_i [ppo_pkg::NUM_LANES],
  input  ppo_pkg::cfg_t                cfg_i,
  output logic                         ready_o,
  output logic                         m_tvalid_o,
  input  wire                          m_tready_i,
  output logic [ppo_pkg::DATA_W-1:0]   m_tdata_o,  // blue, green, red
  output logic                         m_tlast_o
);
  import ppo_pkg::*;

  logic [11:0]          thr_sum;
  logic [17:0]          gray_sum;
  logic [BYTE_W-1:0]    fill;
  logic                 use_fill;
  logic [DATA_W-1:0]    data_d;
  logic                 valid_q, valid_d;
  logic [DATA_W-1:0]    data_q;
  logic                 last_q;

  assign ready_o = !valid_q || m_tready_i;

  always_comb begin
    thr_sum = 12'({lanes_i[0].pix, 1'b0}) + 12'({lanes_i[1].pix, 1'b0})
            + 12'({lanes_i[2].pix, 1'b0}) + 12'(cfg_i.step * 4'd7);
    // gray weights add up to exactly 1024, so the top bits never exceed 255
    gray_sum = 18'(GRAY_W.wr * lanes_i[2].pix) + 18'(GRAY_W.wg * lanes_i[1].pix)
             + 18'(GRAY_W.wb * lanes_i[0].pix);
    use_fill = 1'b0;
    fill     = '0;
    if (cfg_i.true_color) begin
      if (cfg_i.op == OP_THRESHOLD) begin
        use_fill = 1'b1;
        fill     = (thr_sum > THR_LIMIT) ? BYTE_MAX : '0;
      end else if (cfg_i.op == OP_GRAY) begin
        use_fill = 1'b1;
        fill     = gray_sum[17:10];
      end
    end
    for (int i = 0; i < NUM_LANES; i++) begin
      data_d[i*BYTE_W +: BYTE_W] = use_fill ? fill : lanes_i[i].res;
    end
    valid_d = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
      last_q <= last_i;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = data_q;
  assign m_tlast_o  = last_q;

endmodule

`default_nettype wire

/* src/pixel_point_operations.sv */
// Pipeline: an accepted input passes through the lane register, then the output register.
// Throughput: one item per cycle; both stages advance whenever the output is taken.
// A stalled output holds one item in each stage before s_tready_o drops.
// Reset (rst_ni low, asynchronous) empties both stages and sets operation to
// negative, true_color to 1 and brightness_step to 32.
`default_nettype none

`include "pixel_point_operations_assert.svh"

module pixel_point_operations (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [ppo_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [ppo_pkg::CFG_DAT_W-1:0]   cfg_wdata_i,
  input  wire                            s_tvalid_i,
  output logic                           s_tready_o,
  input  wire [ppo_pkg::DATA_W-1:0]      s_tdata_i,  // byte_blue, byte_green, byte_red
  input  wire                            s_tlast_i,  // end_of_image
  output logic                           m_tvalid_o,
  input  wire                            m_tready_i,
  output logic [ppo_pkg::DATA_W-1:0]     m_tdata_o,  // out_blue, out_green, out_red
  output logic                           m_tlast_o   // end_of_image_out
);
  import ppo_pkg::*;

  cfg_t       cfg_q, cfg_d;
  px_t        px;
  lane_out_t  lanes [NUM_LANES];
  logic       v1_q, v1_d;
  logic       last1_q;
  logic       en1;
  logic       m_ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OPERATION:  cfg_d.op         = cfg_wdata_i[2:0];
        REG_TRUE_COLOR: cfg_d.true_color = cfg_wdata_i[0];
        REG_BRIGHTNESS: cfg_d.step       = cfg_wdata_i;
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{op: OP_NEGATIVE, true_color: 1'b1, step: 8'd32};
      v1_q  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      v1_q  <= v1_d;
    end
  end

  assign en1        = !v1_q || m_ready;
  assign s_tready_o = en1;
  assign v1_d       = en1 ? s_tvalid_i : v1_q;

  assign px.blue  = s_tdata_i[0 +: BYTE_W];
  assign px.green = s_tdata_i[BYTE_W +: BYTE_W];
  assign px.red   = s_tdata_i[2*BYTE_W +: BYTE_W];

  always_ff @(posedge clk_i) begin
    if (en1 && s_tvalid_i) begin
      last1_q <= s_tlast_i;
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    ppo_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en1 && s_tvalid_i),
      .px_i  (px),
      .own_i (s_tdata_i[i*BYTE_W +: BYTE_W]),
      .wgt_i (SEPIA_W[i]),
      .cfg_i (cfg_q),
      .out_o (lanes[i])
    );
  end

  ppo_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v1_q),
    .last_i     (last1_q),
    .lanes_i    (lanes),
    .cfg_i      (cfg_q),
    .ready_o    (m_ready),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

  `PPO_ASSERT_NOW(a_no_accept_when_full, s_tvalid_i && s_tready_o,
    !(v1_q && m_tvalid_o && !m_tready_i), "item accepted with both stages stalled")
  `PPO_ASSERT_NEXT(a_stage_moves, v1_q && m_ready, m_tvalid_o,
    "lane item did not reach the output register")
  `PPO_ASSERT_NOW(a_ready_when_empty, !v1_q && !m_tvalid_o, s_tready_o,
    "empty pipeline not ready")
  `PPO_ASSERT_NOW(a_tc_thr_fill, m_tvalid_o && cfg_q.true_color && cfg_q.op == OP_THRESHOLD,
    (m_tdata_o[7:0] == m_tdata_o[15:8]) && (m_tdata_o[15:8] == m_tdata_o[23:16])
      && (m_tdata_o[7:0] == 8'd0 || m_tdata_o[7:0] == 8'd255),
    "true-color threshold bytes differ or not 0/255")

endmodule

`default_nettype wire

/* sim/testbench.sv */
`default_nettype none

module testbench;
  import ppo_pkg::*;

  // codes the block leaves unused: bytes pass through
  localparam logic [2:0] OP_UNUSED_5 = 3'd5;
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic last;
    px_t  px;
  } pixel_item_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata_i = '0;
  logic                 s_tvalid_i  = 1'b0;
  logic                 s_tready_o;
  px_t                  s_tdata_i   = '0;
  logic                 s_tlast_i   = 1'b0;
  logic                 m_tvalid_o;
  logic                 m_tready_i  = 1'b0;
  logic [DATA_W-1:0]    m_tdata_o;
  logic                 m_tlast_o;
  px_t                  out_px;

  assign out_px = m_tdata_o;

  pixel_point_operations u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tlast_i   (s_tlast_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register copy as the block should hold it
  logic [2:0]        cur_op         = OP_NEGATIVE;
  logic              cur_true_color = 1'b1;
  logic [BYTE_W-1:0] cur_step       = 8'd32;

  pixel_item_t expected_pixels[$];
  int unsigned mismatch_count   = 0;
  int unsigned src_idle_max     = 16;
  int unsigned sink_idle_max    = 16;
  int unsigned sink_hold_cycles = 0;

  function automatic logic [BYTE_W-1:0] clip_byte(input int unsigned v);
    return (v > 255) ? BYTE_MAX : v[BYTE_W-1:0];
  endfunction

  // Q0.10 weighted sum, truncated then clipped
  function automatic logic [BYTE_W-1:0] weighted_byte(input int unsigned wr,
                                                      input int unsigned wg,
                                                      input int unsigned wb,
                                                      input px_t p);
    int unsigned acc;
    acc = wr * p.red + wg * p.green + wb * p.blue;
    return clip_byte(acc >> 10);
  endfunction

  function automatic pixel_item_t point_op_result(input px_t p, input logic last);
    pixel_item_t res;
    int unsigned sum;
    res.last = last;
    res.px   = p;
    case (cur_op)
      OP_NEGATIVE: begin
        res.px.blue  = BYTE_MAX - p.blue;
        res.px.green = BYTE_MAX - p.green;
        res.px.red   = BYTE_MAX - p.red;
      end
      OP_BRIGHTEN: begin
        res.px.blue  = clip_byte(p.blue + cur_step);
        res.px.green = clip_byte(p.green + cur_step);
        res.px.red   = clip_byte(p.red + cur_step);
      end
      OP_THRESHOLD: begin
        if (cur_true_color) begin
          sum = p.blue + p.green + p.red;
          res.px.blue = (2 * sum + 7 * cur_step > 764) ? BYTE_MAX : 8'd0;
          res.px.green = res.px.blue;
          res.px.red   = res.px.blue;
        end else begin
          res.px.blue  = (p.blue > 127) ? BYTE_MAX : 8'd0;
          res.px.green = (p.green > 127) ? BYTE_MAX : 8'd0;
          res.px.red   = (p.red > 127) ? BYTE_MAX : 8'd0;
        end
      end
      OP_SEPIA: begin
        res.px.red   = weighted_byte(402, 787, 194, p);
        res.px.green = weighted_byte(357, 702, 172, p);
        res.px.blue  = weighted_byte(279, 547, 134, p);
      end
      OP_GRAY: begin
        if (cur_true_color) begin
          res.px.blue  = weighted_byte(307, 604, 113, p);
          res.px.green = res.px.blue;
          res.px.red   = res.px.blue;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'($urandom_range(127, 128));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic px_t random_px();
    px_t p;
    p.blue  = pick_byte();
    p.green = pick_byte();
    p.red   = pick_byte();
    return p;
  endfunction

  function automatic px_t make_px(input logic [7:0] b, input logic [7:0] g,
                                  input logic [7:0] r);
    px_t p;
    p.blue  = b;
    p.green = g;
    p.red   = r;
    return p;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_OPERATION:  cur_op = value[2:0];
      REG_TRUE_COLOR: cur_true_color = value[0];
      REG_BRIGHTNESS: cur_step = value;
      default: ;
    endcase
  endtask

  task automatic set_operation(input logic [2:0] op);
    write_reg(REG_OPERATION, {5'd0, op});
  endtask

  // valid stays high across back-to-back items; it only drops for a gap
  task automatic send_pixel(input px_t p, input logic last);
    int unsigned gap;
    gap = $urandom_range(src_idle_max, 0);
    if (gap != 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= p;
    s_tlast_i  <= last;
    do @(posedge clk_i); while (!s_tready_o);
    expected_pixels.push_back(point_op_result(p, last));
  endtask

  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (expected_pixels.size() != 0);
  endtask

  task automatic test_reset_config();
    send_pixel(make_px(8'h00, 8'h7F, 8'hFF), 1'b0);
    send_pixel(make_px(8'h80, 8'h01, 8'h5A), 1'b1);
    wait_drained();
  endtask

  task automatic test_each_operation();
    logic [2:0] codes [8];
    codes = '{OP_NEGATIVE, OP_BRIGHTEN, OP_THRESHOLD, OP_SEPIA, OP_GRAY,
              OP_UNUSED_5, OP_UNUSED_6, OP_UNUSED_7};
    foreach (codes[i]) begin
      set_operation(codes[i]);
      send_pixel(make_px(8'h00, 8'h00, 8'h00), 1'b0);
      send_pixel(make_px(8'hFF, 8'hFF, 8'hFF), 1'b1);
      wait_drained();
    end
  endtask

  task automatic test_threshold_edges();
    set_operation(OP_THRESHOLD);
    // step 32: sum 270 sits exactly on the limit, 271 is above
    write_reg(REG_BRIGHTNESS, 8'd32);
    send_pixel(make_px(8'd90, 8'd90, 8'd90), 1'b0);
    send_pixel(make_px(8'd91, 8'd90, 8'd90), 1'b0);
    wait_drained();
    write_reg(REG_BRIGHTNESS, 8'd0);
    send_pixel(make_px(8'd128, 8'd127, 8'd127), 1'b0);
    send_pixel(make_px(8'd128, 8'd128, 8'd127), 1'b1);
    wait_drained();
    write_reg(REG_TRUE_COLOR, 8'd0);
    send_pixel(make_px(8'd127, 8'd128, 8'd255), 1'b0);
    wait_drained();
  endtask

  task automatic test_palette_mode();
    set_operation(OP_GRAY);
    send_pixel(make_px(8'h12, 8'hC3, 8'hFE), 1'b0);
    wait_drained();
    set_operation(OP_SEPIA);
    send_pixel(make_px(8'hFF, 8'h80, 8'h40), 1'b1);
    wait_drained();
    write_reg(REG_TRUE_COLOR, 8'd1);
  endtask

  task automatic test_unused_index();
    set_operation(OP_BRIGHTEN);
    write_reg(REG_BRIGHTNESS, 8'd255);
    // out-of-range index must leave every register alone
    write_reg(REG_UNUSED, 8'h04);
    send_pixel(make_px(8'h00, 8'h01, 8'hFF), 1'b0);
    wait_drained();
  endtask

  task automatic test_random_phases();
    int unsigned op_pick;
    for (int phase = 0; phase < 14; phase++) begin
      op_pick = $urandom_range(0, 7);
      if (op_pick < 7) set_operation(3'($urandom_range(0, 4)));
      else set_operation(3'($urandom_range(5, 7)));
      write_reg(REG_TRUE_COLOR, {7'd0, 1'($urandom_range(0, 1))});
      case (phase)
        0:       write_reg(REG_BRIGHTNESS, 8'd0);
        1:       write_reg(REG_BRIGHTNESS, 8'd255);
        default: write_reg(REG_BRIGHTNESS, pick_byte());
      endcase
      case (phase % 4)
        0: begin src_idle_max = 16; sink_idle_max = 16; end
        1: begin src_idle_max = 0;  sink_idle_max = 16; end
        2: begin src_idle_max = 16; sink_idle_max = 0;  end
        default: begin src_idle_max = 0; sink_idle_max = 0; end
      endcase
      repeat (50) send_pixel(random_px(), $urandom_range(0, 7) == 0);
      wait_drained();
    end
  endtask

  task automatic test_output_stall();
    set_operation(OP_BRIGHTEN);
    write_reg(REG_BRIGHTNESS, 8'd200);
    src_idle_max     = 0;
    sink_hold_cycles = 60;
    repeat (24) send_pixel(random_px(), 1'($urandom_range(0, 1)));
    wait_drained();
  endtask

  // receiver: random stall per item, plus a long hold on request
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (sink_hold_cycles != 0) begin
        m_tready_i <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk_i);
        sink_hold_cycles = 0;
      end else begin
        stall = $urandom_range(sink_idle_max, 0);
        if (stall != 0) begin
          m_tready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o && sink_hold_cycles == 0);
    end
  end

  task automatic report_field(input string field, input logic [7:0] expv,
                              input logic [7:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expv, actv);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    pixel_item_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected item, expected none, got %h last %b",
                 $time, m_tdata_o, m_tlast_o);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        report_field("blue", want.px.blue, out_px.blue);
        report_field("green", want.px.green, out_px.green);
        report_field("red", want.px.red, out_px.red);
        report_field("last", {7'd0, want.last}, {7'd0, m_tlast_o});
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_each_operation();
    test_threshold_edges();
    test_palette_mode();
    test_unused_index();
    test_output_stall();
    test_random_phases();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
